[src/sbbd_pkg.sv]
// ----------------------------------------------------------------------------
// sbbd_pkg
// Shared constants and controller/datapath interface types for the
// spectral band beat detector.
// ----------------------------------------------------------------------------
`default_nettype none

package sbbd_pkg;

    localparam int BAND_COUNT     = 128;
    localparam int FRAMES_KEPT    = 7;
    localparam int BINS_EACH_BAND = 24;

    localparam int FIELD_W  = 28;
    localparam int SQ_W     = 2 * FIELD_W;
    localparam int ENERGY_W = 62;
    localparam int THR_W    = 8;
    localparam logic [THR_W-1:0] THR_RESET = THR_W'(96);

    localparam int MEM_DEPTH = FRAMES_KEPT * BAND_COUNT;
    localparam int ADDR_W    = $clog2(MEM_DEPTH);
    localparam int SLOT_W    = $clog2(FRAMES_KEPT);
    localparam int KCNT_W    = $clog2(FRAMES_KEPT);
    localparam int BAND_W    = $clog2(BAND_COUNT + 1);
    localparam int POS_W     = (BINS_EACH_BAND > 1) ? $clog2(BINS_EACH_BAND) : 1;
    localparam int SUM_W     = ENERGY_W + $clog2(FRAMES_KEPT);
    localparam int PROD_W    = SUM_W + THR_W;
    localparam int BIT_W     = $clog2(THR_W);
    localparam int SCALE     = FRAMES_KEPT * 16;

    typedef struct packed {
        logic clr_wr;
        logic capture;
        logic square;
        logic accum;
        logic hist_wr;
        logic rd_issue;
        logic rd_add;
        logic mul_init;
        logic mul_step;
        logic compare;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic clr_done;
        logic out_free;
        logic in_range;
        logic pos_end;
        logic k_done;
        logic mul_done;
    } t_stat;

endpackage

`default_nettype wire

[src/spectral_band_beat_detector.sv]
// Bins are taken one at a time: each goes through capture, square and
// accumulate; a bin that closes a band adds the history write, the history
// memory walk, the 8-step threshold multiply and the compare. A new bin is
// not taken until the last one is finished and the output register is free.
// Reset is synchronous, active low; after reset a clearing pass zeros all
// FRAMES_KEPT*BAND_COUNT (896) history entries before bins are taken.
// ----------------------------------------------------------------------------
// spectral_band_beat_detector
// Stereo band-energy beat detector over streamed FFT bins.
// ----------------------------------------------------------------------------
`default_nettype none

module spectral_band_beat_detector (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_cfg_we,
    input  wire logic [sbbd_pkg::THR_W-1:0]          i_cfg_data,
    input  wire logic                                i_in_valid,
    output logic                                     o_in_stall,
    input  wire logic signed [sbbd_pkg::FIELD_W-1:0] i_left_real,
    input  wire logic signed [sbbd_pkg::FIELD_W-1:0] i_left_imag,
    input  wire logic signed [sbbd_pkg::FIELD_W-1:0] i_right_real,
    input  wire logic signed [sbbd_pkg::FIELD_W-1:0] i_right_imag,
    input  wire logic                                i_frame_last,
    output logic                                     o_out_valid,
    input  wire logic                                i_out_stall,
    output logic                                     o_beat_any,
    output logic                                     o_beat_left,
    output logic                                     o_beat_right
);
    import sbbd_pkg::*;

    // The controller sequences every transfer; the datapath holds all
    // counters, the two history memories and the output register.
    t_cmd  w_cmd;
    t_stat w_stat;

    sbbd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_stat     (w_stat),
        .o_in_stall (o_in_stall),
        .o_cmd      (w_cmd)
    );

    sbbd_dpath u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_stat       (w_stat),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_data   (i_cfg_data),
        .i_left_real  (i_left_real),
        .i_left_imag  (i_left_imag),
        .i_right_real (i_right_real),
        .i_right_imag (i_right_imag),
        .i_frame_last (i_frame_last),
        .i_out_stall  (i_out_stall),
        .o_out_valid  (o_out_valid),
        .o_beat_any   (o_beat_any),
        .o_beat_left  (o_beat_left),
        .o_beat_right (o_beat_right)
    );

`ifndef SYNTHESIS
    // One bin is worked at a time, so an input transfer always closes the
    // input side for the following cycle.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input taken while a bin was in progress");

    // The summary flag is the OR of the channel flags.
    a_any_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_beat_any == (o_beat_left || o_beat_right)))
        else $error("beat_any does not match channel flags");
`endif

endmodule

`default_nettype wire

[src/sbbd_ctrl.sv]
// ----------------------------------------------------------------------------
// sbbd_ctrl
// Sequencing state machine: clears the history after reset, then walks each
// accepted bin through square, accumulate and, at band ends, history update,
// history sum, threshold multiply and compare.
// ----------------------------------------------------------------------------
`default_nettype none

module sbbd_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    input  wire sbbd_pkg::t_stat i_stat,
    output logic                o_in_stall,
    output sbbd_pkg::t_cmd      o_cmd
);
    import sbbd_pkg::*;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_SQ, S_ACC, S_WR, S_RD, S_ADD, S_MUL, S_CMP
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   w_ready;

    assign w_ready    = (r_state == S_IDLE) && i_stat.out_free;
    assign o_in_stall = !w_ready;

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clr_wr = 1'b1;
                if (i_stat.clr_done) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (w_ready && i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_SQ;
                end
            end
            S_SQ: begin
                o_cmd.square = 1'b1;
                n_state      = S_ACC;
            end
            S_ACC: begin
                if (i_stat.in_range) begin
                    o_cmd.accum = 1'b1;
                end
                if (i_stat.in_range && i_stat.pos_end) begin
                    n_state = S_WR;
                end else begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            S_WR: begin
                o_cmd.hist_wr = 1'b1;
                n_state       = S_RD;
            end
            S_RD: begin
                o_cmd.rd_issue = 1'b1;
                n_state        = S_ADD;
            end
            S_ADD: begin
                o_cmd.rd_add = 1'b1;
                if (i_stat.k_done) begin
                    o_cmd.mul_init = 1'b1;
                    n_state        = S_MUL;
                end else begin
                    n_state = S_RD;
                end
            end
            S_MUL: begin
                o_cmd.mul_step = 1'b1;
                if (i_stat.mul_done) begin
                    n_state = S_CMP;
                end
            end
            S_CMP: begin
                o_cmd.compare = 1'b1;
                o_cmd.finish  = 1'b1;
                n_state       = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

[src/sbbd_dpath.sv]
// ----------------------------------------------------------------------------
// sbbd_dpath
// Datapath: bin power, band accumulators, history memories, serial threshold
// multiplier, comparator and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module sbbd_dpath (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire sbbd_pkg::t_cmd                  i_cmd,
    output sbbd_pkg::t_stat                      o_stat,
    input  wire logic                            i_cfg_we,
    input  wire logic [sbbd_pkg::THR_W-1:0]      i_cfg_data,
    input  wire logic signed [sbbd_pkg::FIELD_W-1:0] i_left_real,
    input  wire logic signed [sbbd_pkg::FIELD_W-1:0] i_left_imag,
    input  wire logic signed [sbbd_pkg::FIELD_W-1:0] i_right_real,
    input  wire logic signed [sbbd_pkg::FIELD_W-1:0] i_right_imag,
    input  wire logic                            i_frame_last,
    input  wire logic                            i_out_stall,
    output logic                                 o_out_valid,
    output logic                                 o_beat_any,
    output logic                                 o_beat_left,
    output logic                                 o_beat_right
);
    import sbbd_pkg::*;

    logic [THR_W-1:0] r_thr;
    logic signed [FIELD_W-1:0] r_lre, r_lim, r_rre, r_rim;
    logic r_last;
    logic [SQ_W-1:0] r_sq_lre, r_sq_lim, r_sq_rre, r_sq_rim;
    logic [ENERGY_W-1:0] r_el, r_er;
    logic [POS_W-1:0]  r_pos;
    logic [BAND_W-1:0] r_band;
    logic [SLOT_W-1:0] r_slot;
    logic [KCNT_W-1:0] r_k;
    logic [ADDR_W-1:0] r_clr;
    logic [SUM_W-1:0]  r_sl, r_sr;
    logic [PROD_W-1:0] r_pl, r_pr;
    logic [BIT_W-1:0]  r_bit;
    logic r_hit_l, r_hit_r;
    logic r_out_valid, r_any, r_bl, r_br;

    logic [ENERGY_W-1:0] mem_l [MEM_DEPTH];
    logic [ENERGY_W-1:0] mem_r [MEM_DEPTH];
    logic [ENERGY_W-1:0] r_rd_l, r_rd_r;

    logic [ADDR_W-1:0]   w_waddr, w_raddr;
    logic [ENERGY_W-1:0] w_wdl, w_wdr;
    logic                w_we;
    logic [PROD_W-1:0]   w_el_scaled, w_er_scaled;
    logic                w_gt_l, w_gt_r, n_hit_l, n_hit_r;
    logic signed [SQ_W-1:0] w_p0, w_p1, w_p2, w_p3;

    assign w_p0 = r_lre * r_lre;
    assign w_p1 = r_lim * r_lim;
    assign w_p2 = r_rre * r_rre;
    assign w_p3 = r_rim * r_rim;

    assign w_raddr = ADDR_W'(int'(r_k) * BAND_COUNT + int'(r_band));
    assign w_waddr = i_cmd.clr_wr ? r_clr
                                  : ADDR_W'(int'(r_slot) * BAND_COUNT + int'(r_band));
    assign w_we    = i_cmd.clr_wr || i_cmd.hist_wr;
    assign w_wdl   = i_cmd.clr_wr ? '0 : r_el;
    assign w_wdr   = i_cmd.clr_wr ? '0 : r_er;

    // Energy times FRAMES_KEPT*16 against threshold times history sum.
    assign w_el_scaled = PROD_W'(r_el) * PROD_W'(SCALE);
    assign w_er_scaled = PROD_W'(r_er) * PROD_W'(SCALE);
    assign w_gt_l  = w_el_scaled > r_pl;
    assign w_gt_r  = w_er_scaled > r_pr;
    assign n_hit_l = r_hit_l || (i_cmd.compare && w_gt_l);
    assign n_hit_r = r_hit_r || (i_cmd.compare && w_gt_r);

    always_comb begin
        o_stat.clr_done = (r_clr == ADDR_W'(MEM_DEPTH - 1));
        o_stat.out_free = !r_out_valid || !i_out_stall;
        o_stat.in_range = (r_band < BAND_W'(BAND_COUNT));
        o_stat.pos_end  = (r_pos == POS_W'(BINS_EACH_BAND - 1));
        o_stat.k_done   = (r_k == KCNT_W'(FRAMES_KEPT - 1));
        o_stat.mul_done = (r_bit == '0);
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem_l[w_waddr] <= w_wdl;
            mem_r[w_waddr] <= w_wdr;
        end
        if (i_cmd.rd_issue) begin
            r_rd_l <= mem_l[w_raddr];
            r_rd_r <= mem_r[w_raddr];
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_lre  <= i_left_real;
            r_lim  <= i_left_imag;
            r_rre  <= i_right_real;
            r_rim  <= i_right_imag;
            r_last <= i_frame_last;
        end
        if (i_cmd.square) begin
            r_sq_lre <= w_p0;
            r_sq_lim <= w_p1;
            r_sq_rre <= w_p2;
            r_sq_rim <= w_p3;
        end
        if (i_cmd.hist_wr) begin
            r_sl <= '0;
            r_sr <= '0;
        end else if (i_cmd.rd_add) begin
            r_sl <= r_sl + SUM_W'(r_rd_l);
            r_sr <= r_sr + SUM_W'(r_rd_r);
        end
        if (i_cmd.mul_init) begin
            r_pl <= '0;
            r_pr <= '0;
        end else if (i_cmd.mul_step) begin
            r_pl <= (r_pl << 1) + (r_thr[r_bit] ? PROD_W'(r_sl) : '0);
            r_pr <= (r_pr << 1) + (r_thr[r_bit] ? PROD_W'(r_sr) : '0);
        end
    end

    // Control-side registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr       <= THR_RESET;
            r_el        <= '0;
            r_er        <= '0;
            r_pos       <= '0;
            r_band      <= '0;
            r_slot      <= '0;
            r_k         <= '0;
            r_clr       <= '0;
            r_bit       <= '0;
            r_hit_l     <= 1'b0;
            r_hit_r     <= 1'b0;
            r_out_valid <= 1'b0;
            r_any       <= 1'b0;
            r_bl        <= 1'b0;
            r_br        <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_thr <= i_cfg_data;
            end
            if (i_cmd.clr_wr) begin
                r_clr <= r_clr + ADDR_W'(1);
            end
            if (i_cmd.accum) begin
                r_el <= r_el + ENERGY_W'(r_sq_lre) + ENERGY_W'(r_sq_lim);
                r_er <= r_er + ENERGY_W'(r_sq_rre) + ENERGY_W'(r_sq_rim);
                if (!o_stat.pos_end) begin
                    r_pos <= r_pos + POS_W'(1);
                end
            end
            if (i_cmd.hist_wr) begin
                r_k <= '0;
            end else if (i_cmd.rd_add) begin
                r_k <= r_k + KCNT_W'(1);
            end
            if (i_cmd.mul_init) begin
                r_bit <= BIT_W'(THR_W - 1);
            end else if (i_cmd.mul_step && !o_stat.mul_done) begin
                r_bit <= r_bit - BIT_W'(1);
            end
            if (i_cmd.compare) begin
                r_el    <= '0;
                r_er    <= '0;
                r_pos   <= '0;
                r_band  <= r_band + BAND_W'(1);
                r_hit_l <= n_hit_l;
                r_hit_r <= n_hit_r;
            end
            if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (i_cmd.finish && r_last) begin
                r_out_valid <= 1'b1;
                r_any       <= n_hit_l || n_hit_r;
                r_bl        <= n_hit_l;
                r_br        <= n_hit_r;
                r_el        <= '0;
                r_er        <= '0;
                r_pos       <= '0;
                r_band      <= '0;
                r_hit_l     <= 1'b0;
                r_hit_r     <= 1'b0;
                r_slot      <= (r_slot == SLOT_W'(FRAMES_KEPT - 1)) ? '0
                                                                    : r_slot + SLOT_W'(1);
            end
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_beat_any   = r_any;
    assign o_beat_left  = r_bl;
    assign o_beat_right = r_br;

endmodule

`default_nettype wire
